// File: hw/rtl/yuyv422_to_yuv420p_half_scaler_core_defines.svh
// Assertion macros shared by the checker of the half-scale YUV420p converter.
`ifndef YUYV422_TO_YUV420P_HALF_SCALER_CORE_DEFINES_SVH
`define YUYV422_TO_YUV420P_HALF_SCALER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define YHS_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define YHS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/yuv2p_hs_pkg.sv
// Package with the constants, types and helper functions of the half-scale converter.
`timescale 1ns / 1ps
package yuv2p_hs_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int LUMA_DEPTH   = MAX_WIDTH / 2;
    localparam int CHROMA_DEPTH = MAX_WIDTH / 4;

    localparam int COL_W    = $clog2(LUMA_DEPTH);
    localparam int CHR_AW   = $clog2(CHROMA_DEPTH);
    localparam int LINE_W   = $clog2(MAX_HEIGHT);
    localparam int MPL_W    = $clog2(LUMA_DEPTH + 1);
    localparam int LINES_W  = $clog2(MAX_HEIGHT + 1);

    localparam int CFG_W    = 12;
    localparam int SAMPLE_W = 8;
    localparam int PAIR_W   = 9;
    localparam int PART_W   = 10;
    localparam int OUT_W    = 10;
    localparam int PLANE_W  = 2;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam int MAX_RESULTS = 3;
    localparam int PUSH_W      = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [PLANE_W-1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_BLUE = 2'd1,
        PLANE_RED  = 2'd2
    } t_plane;

    // Position of a line within its band of four.
    typedef enum logic [1:0] {
        PH_TOP_A = 2'd0,
        PH_TOP_B = 2'd1,
        PH_BOT_A = 2'd2,
        PH_BOT_B = 2'd3
    } t_phase;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        t_phase            phase;
        logic [OUT_W-1:0]  row_l;
        logic [OUT_W-1:0]  row_c;
        logic [PAIR_W-1:0] pair;
        logic [PAIR_W-1:0] su;
        logic [PAIR_W-1:0] sv;
    } t_stage;

    typedef struct packed {
        logic [PART_W-1:0]   blue_part;
        logic [PART_W-1:0]   red_part;
        logic [SAMPLE_W-1:0] blue_top;
        logic [SAMPLE_W-1:0] red_top;
    } t_chroma_entry;

    typedef struct packed {
        logic [PLANE_W-1:0]  plane;
        logic [OUT_W-1:0]    col;
        logic [OUT_W-1:0]    row;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [PUSH_W-1:0]                count;
        t_result [MAX_RESULTS-1:0] slot;
    } t_push;

    // Macropixels per line from the raw width register.
    function automatic logic [MPL_W-1:0] mp_per_line(input logic [CFG_W-1:0] raw);
        logic [CFG_W-1:0] v;
        v = {raw[CFG_W-1:2], 2'b00};
        if (v < CFG_W'(4)) v = CFG_W'(4);
        if (int'(v) > MAX_WIDTH) v = CFG_W'(MAX_WIDTH);
        return MPL_W'(v >> 1);
    endfunction

    // Lines per frame from the raw height register.
    function automatic logic [LINES_W-1:0] lines_per_frame(input logic [CFG_W-1:0] raw);
        logic [CFG_W-1:0] v;
        v = {raw[CFG_W-1:2], 2'b00};
        if (v < CFG_W'(4)) v = CFG_W'(4);
        if (int'(v) > MAX_HEIGHT) v = CFG_W'(MAX_HEIGHT);
        return LINES_W'(v);
    endfunction

endpackage

// File: hw/rtl/yuv2p_hs_ifs.sv
// Valid/ready stream interfaces for macropixel requests and addressed output samples.
`timescale 1ns / 1ps
interface yuv2p_hs_in_if;
    import yuv2p_hs_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] first_luma;
    logic [SAMPLE_W-1:0] blue_chroma;
    logic [SAMPLE_W-1:0] second_luma;
    logic [SAMPLE_W-1:0] red_chroma;
    modport source (output valid, first_luma, blue_chroma, second_luma, red_chroma,
                    input ready);
    modport sink (input valid, first_luma, blue_chroma, second_luma, red_chroma,
                  output ready);
endinterface

interface yuv2p_hs_out_if;
    import yuv2p_hs_pkg::*;
    logic                valid;
    logic                ready;
    logic [PLANE_W-1:0]  plane;
    logic [OUT_W-1:0]    out_column;
    logic [OUT_W-1:0]    out_row;
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_of_run;
    modport source (output valid, plane, out_column, out_row, sample_value, last_of_run,
                    input ready);
    modport sink (input valid, plane, out_column, out_row, sample_value, last_of_run,
                  output ready);
endinterface

// File: hw/rtl/yuyv422_to_yuv420p_half_scaler_core.sv
// Top level of the YUYV422 to half-scale planar YUV420p converter.
//
//  Channel  Direction  Handshake              Contents
//  i_pix    in         valid / ready          one YUYV macropixel (y0, u, y1, v)
//  o_res    out        valid / ready          plane, column, row, sample, last flag
//  APB      in         psel / penable / pwrite width and height registers, readable
//
// A request is taken every cycle while the result queue has room; each request
// passes through one stage register, while the line stores are read, and the cycle
// after that it updates the stores and drops its results into the queue.
// Luma lines give at most one result per request, so while the output takes results
// the block keeps one request a cycle there; chroma pairs on the fourth line of a
// band give three, and the single output port then sets the pace.
// Reset is synchronous and clears the counters, registers and queue; the line
// stores are not cleared and need no clearing pass, as every entry is written before
// it is read. Output stalls hold back new requests once the queue holds three
// results with a request in the stage, or six with the stage empty.
`timescale 1ns / 1ps
module yuyv422_to_yuv420p_half_scaler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    yuv2p_hs_in_if.sink                       i_pix,
    yuv2p_hs_out_if.source                    o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yuv2p_hs_pkg::APB_AW-1:0]   paddr,
    input  logic [yuv2p_hs_pkg::APB_DW-1:0]   pwdata,
    output logic [yuv2p_hs_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import yuv2p_hs_pkg::*;

    // Configuration port. Registers sit four bytes apart, so bit two picks one.
    logic             cfg_we;
    t_reg_idx         cfg_idx;
    logic [CFG_W-1:0] width_raw;
    logic [CFG_W-1:0] height_raw;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = APB_DW'(width_raw);
            REG_HEIGHT: prdata = APB_DW'(height_raw);
            default:    prdata = '0;
        endcase
    end

    // Admission. A request in the stage register and the one about to be taken may
    // each push three results, so room for both is reserved before accepting.
    logic               accept;
    logic               s1_valid;
    logic [FIFO_CW-1:0] q_count;
    logic               room;

    assign room = s1_valid ? (int'(q_count) <= FIFO_DEPTH - 2 * MAX_RESULTS)
                           : (int'(q_count) <= FIFO_DEPTH - MAX_RESULTS);
    assign i_pix.ready = room;
    assign accept      = i_pix.valid && i_pix.ready;

    // Position counters and the stage register. The store read addresses are taken
    // from the current position at the edge that accepts the request.
    t_stage            s1;
    logic [COL_W-1:0]  rd_col;
    logic [CHR_AW-1:0] rd_chr;

    yuv2p_hs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (pwdata[CFG_W-1:0]),
        .i_accept      (accept),
        .i_first_luma  (i_pix.first_luma),
        .i_blue_chroma (i_pix.blue_chroma),
        .i_second_luma (i_pix.second_luma),
        .i_red_chroma  (i_pix.red_chroma),
        .o_width_raw   (width_raw),
        .o_height_raw  (height_raw),
        .o_rd_col      (rd_col),
        .o_rd_chr      (rd_chr),
        .o_s1_valid    (s1_valid),
        .o_s1          (s1)
    );

    // Line stores. The luma store keeps the pair sums of the even line; the chroma
    // store keeps, per pair of macropixels, the running partial sums and the top
    // quarters of the current band. Two requests that touch the same entry are at
    // least a whole line apart (a line holds two macropixels or more, and chroma
    // entries are touched only at odd columns), so a write always lands before the
    // next read of that entry and no forwarding path is needed.
    logic                luma_we;
    logic [COL_W-1:0]    luma_waddr;
    logic [PAIR_W-1:0]   luma_wdata;
    logic [PAIR_W-1:0]   luma_rdata;
    logic                chr_we;
    logic [CHR_AW-1:0]   chr_waddr;
    t_chroma_entry       chr_wdata;
    t_chroma_entry       chr_rdata;

    yuv2p_hs_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LUMA_DEPTH)
    ) u_luma_ram (
        .i_clk   (i_clk),
        .i_we    (luma_we),
        .i_waddr (luma_waddr),
        .i_wdata (luma_wdata),
        .i_re    (accept),
        .i_raddr (rd_col),
        .o_rdata (luma_rdata)
    );

    yuv2p_hs_ram #(
        .WIDTH ($bits(t_chroma_entry)),
        .DEPTH (CHROMA_DEPTH)
    ) u_chroma_ram (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (chr_waddr),
        .i_wdata (chr_wdata),
        .i_re    (accept),
        .i_raddr (rd_chr),
        .o_rdata (chr_rdata)
    );

    // Arithmetic and write-back, in the cycle after acceptance.
    t_push push;

    yuv2p_hs_calc u_calc (
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_luma_rd   (luma_rdata),
        .i_chr_rd    (chr_rdata),
        .o_luma_we   (luma_we),
        .o_luma_addr (luma_waddr),
        .o_luma_data (luma_wdata),
        .o_chr_we    (chr_we),
        .o_chr_addr  (chr_waddr),
        .o_chr_data  (chr_wdata),
        .o_push      (push)
    );

    // Result queue, which also serves as the output register.
    yuv2p_hs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_res   (o_res)
    );
endmodule

// File: hw/rtl/yuv2p_hs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module yuv2p_hs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/yuv2p_hs_seq.sv
// Configuration registers, raster position counters and the request stage register.
`timescale 1ns / 1ps
module yuv2p_hs_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  yuv2p_hs_pkg::t_reg_idx              i_cfg_idx,
    input  logic [yuv2p_hs_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  logic [yuv2p_hs_pkg::SAMPLE_W-1:0]   i_first_luma,
    input  logic [yuv2p_hs_pkg::SAMPLE_W-1:0]   i_blue_chroma,
    input  logic [yuv2p_hs_pkg::SAMPLE_W-1:0]   i_second_luma,
    input  logic [yuv2p_hs_pkg::SAMPLE_W-1:0]   i_red_chroma,
    output logic [yuv2p_hs_pkg::CFG_W-1:0]      o_width_raw,
    output logic [yuv2p_hs_pkg::CFG_W-1:0]      o_height_raw,
    output logic [yuv2p_hs_pkg::COL_W-1:0]      o_rd_col,
    output logic [yuv2p_hs_pkg::CHR_AW-1:0]     o_rd_chr,
    output logic                                o_s1_valid,
    output yuv2p_hs_pkg::t_stage                o_s1
);
    import yuv2p_hs_pkg::*;

    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [MPL_W-1:0]    r_mpl;
    logic [LINES_W-1:0]  r_lines;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [LINE_W-1:0]   r_line;
    logic [LINE_W-1:0]   n_line;
    logic [SAMPLE_W-1:0] r_held_u;
    logic [SAMPLE_W-1:0] r_held_v;
    logic                r_s1_valid;
    t_stage              r_s1;
    t_stage              n_s1;

    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        if (i_cfg_we) begin
            n_col  = '0;
            n_line = '0;
        end else if (i_accept) begin
            if ((MPL_W'(r_col) + MPL_W'(1)) >= r_mpl) begin
                n_col = '0;
                if ((LINES_W'(r_line) + LINES_W'(1)) >= r_lines) begin
                    n_line = '0;
                end else begin
                    n_line = r_line + LINE_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_comb begin
        n_s1.col   = r_col;
        n_s1.phase = t_phase'(r_line[1:0]);
        n_s1.row_l = OUT_W'(r_line >> 1);
        n_s1.row_c = OUT_W'(r_line >> 2);
        n_s1.pair  = PAIR_W'(i_first_luma) + PAIR_W'(i_second_luma);
        n_s1.su    = PAIR_W'(r_held_u) + PAIR_W'(i_blue_chroma);
        n_s1.sv    = PAIR_W'(r_held_v) + PAIR_W'(i_red_chroma);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
            r_mpl      <= mp_per_line(WIDTH_RESET);
            r_lines    <= lines_per_frame(HEIGHT_RESET);
            r_col      <= '0;
            r_line     <= '0;
            r_held_u   <= '0;
            r_held_v   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_line     <= n_line;
            r_s1_valid <= i_accept;
            if (i_cfg_we && (i_cfg_idx == REG_WIDTH)) begin
                r_width <= i_cfg_data;
                r_mpl   <= mp_per_line(i_cfg_data);
            end
            if (i_cfg_we && (i_cfg_idx == REG_HEIGHT)) begin
                r_height <= i_cfg_data;
                r_lines  <= lines_per_frame(i_cfg_data);
            end
            if (i_accept && !r_col[0]) begin
                r_held_u <= i_blue_chroma;
                r_held_v <= i_red_chroma;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_width_raw  = r_width;
    assign o_height_raw = r_height;
    assign o_rd_col     = r_col;
    assign o_rd_chr     = r_col[COL_W-1:1];
    assign o_s1_valid   = r_s1_valid;
    assign o_s1         = r_s1;
endmodule

// File: hw/rtl/yuv2p_hs_calc.sv
// Read-modify-write of the line stores and assembly of up to three results per request.
`timescale 1ns / 1ps
module yuv2p_hs_calc (
    input  logic                               i_s1_valid,
    input  yuv2p_hs_pkg::t_stage               i_s1,
    input  logic [yuv2p_hs_pkg::PAIR_W-1:0]    i_luma_rd,
    input  yuv2p_hs_pkg::t_chroma_entry        i_chr_rd,
    output logic                               o_luma_we,
    output logic [yuv2p_hs_pkg::COL_W-1:0]     o_luma_addr,
    output logic [yuv2p_hs_pkg::PAIR_W-1:0]    o_luma_data,
    output logic                               o_chr_we,
    output logic [yuv2p_hs_pkg::CHR_AW-1:0]    o_chr_addr,
    output yuv2p_hs_pkg::t_chroma_entry        o_chr_data,
    output yuv2p_hs_pkg::t_push                o_push
);
    import yuv2p_hs_pkg::*;

    logic [PAIR_W:0]     lsum;
    logic [PART_W:0]     bsum;
    logic [PART_W:0]     rsum;
    logic [SAMPLE_W-1:0] bq;
    logic [SAMPLE_W-1:0] rq;
    logic [SAMPLE_W:0]   usum;
    logic [SAMPLE_W:0]   vsum;
    logic                has_luma;
    logic                has_chroma;
    t_result             res_l;
    t_result             res_u;
    t_result             res_v;

    // Luma: the even line parks its pair sum, the odd line completes the 2x2 block.
    assign lsum        = (PAIR_W+1)'(i_luma_rd) + (PAIR_W+1)'(i_s1.pair);
    assign o_luma_we   = i_s1_valid && !i_s1.phase[0];
    assign o_luma_addr = i_s1.col;
    assign o_luma_data = i_s1.pair;

    // Chroma: quarter of a line pair, then the mean of the top and bottom quarters.
    assign bsum = (PART_W+1)'(i_chr_rd.blue_part) + (PART_W+1)'(i_s1.su);
    assign rsum = (PART_W+1)'(i_chr_rd.red_part) + (PART_W+1)'(i_s1.sv);
    assign bq   = SAMPLE_W'(bsum >> 2);
    assign rq   = SAMPLE_W'(rsum >> 2);
    assign usum = (SAMPLE_W+1)'(i_chr_rd.blue_top) + (SAMPLE_W+1)'(bq);
    assign vsum = (SAMPLE_W+1)'(i_chr_rd.red_top) + (SAMPLE_W+1)'(rq);

    assign o_chr_addr = i_s1.col[COL_W-1:1];
    assign o_chr_we   = i_s1_valid && i_s1.col[0] && (i_s1.phase != PH_BOT_B);

    always_comb begin
        o_chr_data = i_chr_rd;
        unique case (i_s1.phase)
            PH_TOP_A, PH_BOT_A: begin
                o_chr_data.blue_part = PART_W'(i_s1.su);
                o_chr_data.red_part  = PART_W'(i_s1.sv);
            end
            PH_TOP_B: begin
                o_chr_data.blue_top = bq;
                o_chr_data.red_top  = rq;
            end
            PH_BOT_B: begin
                o_chr_data = i_chr_rd;
            end
            default: begin
                o_chr_data = i_chr_rd;
            end
        endcase
    end

    assign has_luma   = i_s1_valid && i_s1.phase[0];
    assign has_chroma = i_s1_valid && i_s1.col[0] && (i_s1.phase == PH_BOT_B);

    always_comb begin
        res_l.plane = PLANE_LUMA;
        res_l.col   = OUT_W'(i_s1.col);
        res_l.row   = i_s1.row_l;
        res_l.value = SAMPLE_W'(lsum >> 2);
        res_l.last  = !has_chroma;

        res_u.plane = PLANE_BLUE;
        res_u.col   = OUT_W'(i_s1.col >> 1);
        res_u.row   = i_s1.row_c;
        res_u.value = usum[SAMPLE_W:1];
        res_u.last  = 1'b0;

        res_v       = res_u;
        res_v.plane = PLANE_RED;
        res_v.value = vsum[SAMPLE_W:1];
        res_v.last  = 1'b1;

        o_push.count = PUSH_W'(has_luma) + (has_chroma ? PUSH_W'(2) : PUSH_W'(0));
        if (has_luma) begin
            o_push.slot[0] = res_l;
            o_push.slot[1] = res_u;
            o_push.slot[2] = res_v;
        end else begin
            o_push.slot[0] = res_u;
            o_push.slot[1] = res_v;
            o_push.slot[2] = res_v;
        end
    end
endmodule

// File: hw/rtl/yuv2p_hs_fifo.sv
// Result queue that takes up to three results a cycle and hands out one a cycle while the output is ready.
`timescale 1ns / 1ps
module yuv2p_hs_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  yuv2p_hs_pkg::t_push               i_push,
    output logic [yuv2p_hs_pkg::FIFO_CW-1:0]  o_count,
    yuv2p_hs_out_if.source                    o_res
);
    import yuv2p_hs_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic               pop;
    t_result            head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (i < int'(i_push.count)) begin
                r_mem[FIFO_AW'(r_wptr + FIFO_AW'(i))] <= i_push.slot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_AW'(i_push.count);
            r_rptr  <= r_rptr + FIFO_AW'(pop);
            r_count <= r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
        end
    end

    assign o_count            = r_count;
    assign o_res.valid        = (r_count != '0);
    assign o_res.plane        = head.plane;
    assign o_res.out_column   = head.col;
    assign o_res.out_row      = head.row;
    assign o_res.sample_value = head.value;
    assign o_res.last_of_run  = head.last;
endmodule

// File: hw/rtl/yuv2p_hs_chk.sv
// Port-level checker of the half-scale converter, bound to the top level.
`timescale 1ns / 1ps
`include "yuyv422_to_yuv420p_half_scaler_core_defines.svh"
module yuv2p_hs_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_res_valid,
    input logic                                i_res_ready,
    input logic [yuv2p_hs_pkg::PLANE_W-1:0]    i_res_plane,
    input logic [yuv2p_hs_pkg::OUT_W-1:0]      i_res_col,
    input logic [yuv2p_hs_pkg::OUT_W-1:0]      i_res_row,
    input logic [yuv2p_hs_pkg::SAMPLE_W-1:0]   i_res_value,
    input logic                                i_res_last,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [yuv2p_hs_pkg::APB_AW-1:0]     paddr,
    input logic [yuv2p_hs_pkg::APB_DW-1:0]     pwdata,
    input logic [yuv2p_hs_pkg::APB_DW-1:0]     prdata
);
    import yuv2p_hs_pkg::*;

    // Nothing is offered in the cycle after a reset.
    `YHS_ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !i_res_valid, "output valid after reset")

    // A U sample never closes a request and a V sample always does.
    `YHS_ASSERT_IMPLY(a_blue_not_last, i_clk, !i_rst_n, i_res_valid && (i_res_plane == PLANE_BLUE), !i_res_last, "U sample marked last")
    `YHS_ASSERT_IMPLY(a_red_last, i_clk, !i_rst_n, i_res_valid && (i_res_plane == PLANE_RED), i_res_last, "V sample not marked last")

    // A width written is read back in the following cycle.
    `YHS_ASSERT_NEXT(a_width_readback, i_clk, !i_rst_n, psel && penable && pwrite && (paddr[2] == REG_WIDTH), !(paddr[2] == REG_WIDTH) || (prdata == APB_DW'($past(pwdata[CFG_W-1:0]))), "width register read-back mismatch")

    // A stalled result holds its contents.
    `YHS_ASSERT_NEXT(a_stall_hold, i_clk, !i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_plane) && $stable(i_res_col) && $stable(i_res_row) && $stable(i_res_value) && $stable(i_res_last), "stalled result changed")
endmodule

bind yuyv422_to_yuv420p_half_scaler_core yuv2p_hs_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_plane (o_res.plane),
    .i_res_col   (o_res.out_column),
    .i_res_row   (o_res.out_row),
    .i_res_value (o_res.sample_value),
    .i_res_last  (o_res.last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
